@@ sv/utf8d_pkg.sv @@
// shared types, constants and the overlong limit table for the utf-8 stream decoder
package utf8d_pkg;

	localparam int unsigned CP_W   = 31;
	localparam int unsigned LEN_W  = 3;
	localparam int unsigned ST_W   = 2;
	localparam int unsigned BYTE_W = 8;

	// status codes
	localparam logic [ST_W-1:0] ST_OK  = 2'd0;
	localparam logic [ST_W-1:0] ST_ERR = 2'd1;
	localparam logic [ST_W-1:0] ST_END = 2'd2;

	typedef struct packed {
		logic [LEN_W-1:0] rem;
		logic [CP_W-1:0]  partial;
		logic [LEN_W-1:0] total;
	} dec_state_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [ST_W-1:0]  status;
		logic [LEN_W-1:0] seq_length;
	} dec_result_t;

	// largest value that is overlong for a sequence of the given length
	function automatic logic [CP_W-1:0] overlong_limit(input logic [LEN_W-1:0] len);
		logic [CP_W-1:0] lim;
		lim = '0;
		case (len)
			3'd2:    lim = 31'h0000007f;
			3'd3:    lim = 31'h000007ff;
			3'd4:    lim = 31'h0000ffff;
			3'd5:    lim = 31'h001fffff;
			3'd6:    lim = 31'h03ffffff;
			3'd7:    lim = 31'h03ffffff;
			default: lim = '0;
		endcase
		return lim;
	endfunction

endpackage

@@ sv/utf8d_step.sv @@
// combinational decode of one byte against the current sequence state
module utf8d_step (
	input  utf8d_pkg::dec_state_t   cur,
	input  logic [7:0]              byte_in,
	output utf8d_pkg::dec_state_t   nxt,
	output logic                    res_valid,
	output utf8d_pkg::dec_result_t  res
);

	localparam utf8d_pkg::dec_state_t IDLE_STATE = '0;

	logic [utf8d_pkg::CP_W-1:0]  shifted;
	logic [utf8d_pkg::LEN_W-1:0] rem_dec;

	assign shifted = {cur.partial[utf8d_pkg::CP_W-7:0], byte_in[5:0]};
	assign rem_dec = cur.rem - 3'd1;

	always_comb begin
		nxt       = cur;
		res_valid = 1'b0;
		res       = '0;
		if (cur.rem == 3'd0) begin
			if (byte_in == 8'h00) begin
				res_valid  = 1'b1;
				res.status = utf8d_pkg::ST_END;
			end else if (!byte_in[7]) begin
				res_valid      = 1'b1;
				res.code_point = {23'd0, byte_in};
				res.status     = utf8d_pkg::ST_OK;
				res.seq_length = 3'd1;
			end else if ((byte_in & 8'he0) == 8'hc0) begin
				nxt.partial = {26'd0, byte_in[4:0]};
				nxt.total   = 3'd2;
				nxt.rem     = 3'd1;
			end else if ((byte_in & 8'hf0) == 8'he0) begin
				nxt.partial = {27'd0, byte_in[3:0]};
				nxt.total   = 3'd3;
				nxt.rem     = 3'd2;
			end else if ((byte_in & 8'hf8) == 8'hf0) begin
				nxt.partial = {28'd0, byte_in[2:0]};
				nxt.total   = 3'd4;
				nxt.rem     = 3'd3;
			end else if ((byte_in & 8'hfc) == 8'hf8) begin
				nxt.partial = {29'd0, byte_in[1:0]};
				nxt.total   = 3'd5;
				nxt.rem     = 3'd4;
			end else if ((byte_in & 8'hfe) == 8'hfc) begin
				nxt.partial = {30'd0, byte_in[0]};
				nxt.total   = 3'd6;
				nxt.rem     = 3'd5;
			end else begin
				// stray continuation byte or 0xfe/0xff
				nxt        = IDLE_STATE;
				res_valid  = 1'b1;
				res.status = utf8d_pkg::ST_ERR;
			end
		end else if (byte_in[7:6] != 2'b10) begin
			// broken sequence, offending byte dropped
			nxt        = IDLE_STATE;
			res_valid  = 1'b1;
			res.status = utf8d_pkg::ST_ERR;
		end else if (rem_dec != 3'd0) begin
			nxt.partial = shifted;
			nxt.rem     = rem_dec;
		end else begin
			nxt       = IDLE_STATE;
			res_valid = 1'b1;
			if (shifted <= utf8d_pkg::overlong_limit(cur.total)) begin
				res.status = utf8d_pkg::ST_ERR;
			end else begin
				res.code_point = shifted;
				res.status     = utf8d_pkg::ST_OK;
				res.seq_length = cur.total;
			end
		end
	end

endmodule

@@ sv/utf8_stream_decoder.sv @@
// top level of the utf-8 stream decoder: input stage, decode step, result register
//
//  channel | dir | tdata (low bit up)                      | tuser
//  s_*     | in  | [7:0] data_byte                         | -
//  m_*     | out | [30:0] code_point, [33:31] seq_length   | [1:0] status
//
// one byte per cycle sustained while the output is not stalled; a byte is registered
// in the input stage, and its result is registered in the result register behind m_tvalid
// the whole per-byte decode is one pass of the step logic, which also updates the
// sequence state; lead and middle bytes of a sequence give no transfer out
// arst_n clears the sequence state and both valid flags
// a stalled output only holds the input stage when that byte would produce a result
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [30:0] code_point, [33:31] seq_length, rest zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// decoder state carried between bytes
	utf8d_pkg::dec_state_t state_q;
	utf8d_pkg::dec_state_t state_nxt;

	// step outputs
	logic                   res_valid;
	utf8d_pkg::dec_result_t res;

	// result register
	logic                   valid_s2;
	utf8d_pkg::dec_result_t res_s2;

	logic out_free;
	logic s1_fire;
	logic in_fire;

	utf8d_step u_step (
		.cur       (state_q),
		.byte_in   (byte_s1),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register is free when empty or being drained this cycle
	assign out_free = !valid_s2 || m_tready;
	// a byte leaves the input stage unless it has a result with nowhere to go
	assign s1_fire  = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || s1_fire;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_fire && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.seq_length, res_s2.code_point};
	assign m_tuser  = res_s2.status;

`ifndef SYNTHESIS
	// mid-sequence the remaining count stays below the sequence length
	a_rem_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.rem != 3'd0 |-> (state_q.rem < state_q.total && state_q.total >= 3'd2))
		else $error("remaining byte count out of step with sequence length");

	// error and end transfers carry no code point and no length
	a_nonok_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != utf8d_pkg::ST_OK) |-> (m_tdata == 40'd0))
		else $error("non-ok transfer carries payload");

	// ok transfers have a length of one to six and no unused status code appears
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != 2'd3 &&
			(m_tuser != utf8d_pkg::ST_OK ||
			 (m_tdata[33:31] != 3'd0 && m_tdata[33:31] != 3'd7))))
		else $error("bad status or length on output");

	// a held input byte only waits on a blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_fire) |-> (valid_s2 && !m_tready && res_valid))
		else $error("input stage stalled without output back-pressure");
`endif

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the utf-8 stream decoder: random and directed byte streams
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned RANDOM_BYTES = 1600;
	localparam int unsigned QUIET_TAIL   = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;           // [30:0] code_point, [33:31] seq_length
	logic [1:0]  m_tuser;           // [1:0] status

	utf8_stream_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// bytes still to be sent, and decoded characters still due at the output
	logic [7:0]             byte_backlog [$];
	utf8d_pkg::dec_result_t cp_due [$];

	// sequence state of the decoder as the checker sees it
	logic [utf8d_pkg::LEN_W-1:0] seq_left = '0;
	logic [utf8d_pkg::CP_W-1:0]  seq_acc  = '0;
	logic [utf8d_pkg::LEN_W-1:0] seq_len  = '0;

	int unsigned total_bytes = 0;
	int unsigned sent_cnt    = 0;
	int unsigned fault_cnt   = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic push_result(input logic [utf8d_pkg::CP_W-1:0] cp,
			input logic [utf8d_pkg::ST_W-1:0] st,
			input logic [utf8d_pkg::LEN_W-1:0] len);
		utf8d_pkg::dec_result_t r;
		r.code_point = cp;
		r.status     = st;
		r.seq_length = len;
		cp_due.push_back(r);
	endtask

	// advance the checker's decoder by one accepted byte
	task automatic decode_byte(input logic [7:0] b);
		logic [utf8d_pkg::CP_W-1:0] ceiling;
		if (seq_left == 0) begin
			seq_acc = '0;
			seq_len = '0;
			casez (b)
				8'b0000_0000: push_result('0, utf8d_pkg::ST_END, 3'd0);
				8'b0???_????: push_result({23'd0, b}, utf8d_pkg::ST_OK, 3'd1);
				8'b110?_????: begin seq_acc = {26'd0, b[4:0]}; seq_len = 3'd2; end
				8'b1110_????: begin seq_acc = {27'd0, b[3:0]}; seq_len = 3'd3; end
				8'b1111_0???: begin seq_acc = {28'd0, b[2:0]}; seq_len = 3'd4; end
				8'b1111_10??: begin seq_acc = {29'd0, b[1:0]}; seq_len = 3'd5; end
				8'b1111_110?: begin seq_acc = {30'd0, b[0]};   seq_len = 3'd6; end
				// stray continuation, 0xfe and 0xff
				default:      push_result('0, utf8d_pkg::ST_ERR, 3'd0);
			endcase
			if (seq_len != 0)
				seq_left = seq_len - 3'd1;
		end else if (b[7:6] != 2'b10) begin
			// nul or any non-continuation byte kills the sequence and is dropped
			seq_left = '0;
			push_result('0, utf8d_pkg::ST_ERR, 3'd0);
		end else begin
			seq_acc  = {seq_acc[utf8d_pkg::CP_W-7:0], b[5:0]};
			seq_left = seq_left - 3'd1;
			if (seq_left == 0) begin
				case (seq_len)
					3'd2:    ceiling = 31'h7f;
					3'd3:    ceiling = 31'h7ff;
					3'd4:    ceiling = 31'hffff;
					3'd5:    ceiling = 31'h1fffff;
					default: ceiling = 31'h3ffffff;
				endcase
				if (seq_acc <= ceiling)
					push_result('0, utf8d_pkg::ST_ERR, 3'd0);
				else
					push_result(seq_acc, utf8d_pkg::ST_OK, seq_len);
			end
		end
	endtask

	// lead byte of an n-byte sequence carrying the given top payload bits
	function automatic logic [7:0] lead_byte(input int n, input logic [7:0] payload);
		case (n)
			2:       return 8'hc0 | (payload & 8'h1f);
			3:       return 8'he0 | (payload & 8'h0f);
			4:       return 8'hf0 | (payload & 8'h07);
			5:       return 8'hf8 | (payload & 8'h03);
			default: return 8'hfc | (payload & 8'h01);
		endcase
	endfunction

	task automatic encode_cp(input int n, input logic [31:0] v);
		if (n == 1) begin
			byte_backlog.push_back({1'b0, v[6:0]});
		end else begin
			byte_backlog.push_back(lead_byte(n, 8'(v >> (6 * (n - 1)))));
			for (int i = n - 2; i >= 0; i--)
				byte_backlog.push_back(8'h80 | 8'((v >> (6 * i)) & 32'h3f));
		end
	endtask

	// payload width of an n-byte sequence
	function automatic int payload_bits(input int n);
		return (n == 1) ? 7 : 5 * n + 1;
	endfunction

	// pick an idle percentage; zero gives stretches with no idling at all
	function automatic int idle_pct();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 5;
			2:       return 15;
			default: return 40;
		endcase
	endfunction

	// byte driver
	always @(posedge clk) begin : drive_bytes
		logic        nv;
		int unsigned gap_left;
		int unsigned pct;
		int unsigned tick;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata);
				void'(byte_backlog.pop_front());
				sent_cnt++;
			end
			if (tick % 64 == 0)
				pct = idle_pct();
			tick++;
			// a byte offered but not taken stays on the bus
			nv = s_tvalid && !s_tready;
			if (!nv) begin
				if (gap_left > 0)
					gap_left--;
				else if (byte_backlog.size() != 0) begin
					if (sent_cnt + QUIET_TAIL < total_bytes && $urandom_range(0, 99) < pct)
						gap_left = $urandom_range(1, 12) - 1;
					else
						nv = 1'b1;
				end
			end
			s_tvalid <= nv;
			if (nv)
				s_tdata <= byte_backlog[0];
		end
	end

	// result monitor and backpressure
	always @(posedge clk) begin : watch_results
		logic [utf8d_pkg::CP_W-1:0]  got_cp;
		logic [utf8d_pkg::LEN_W-1:0] got_len;
		logic [utf8d_pkg::ST_W-1:0]  got_st;
		utf8d_pkg::dec_result_t      want;
		int unsigned                 stall_left;
		int unsigned                 pct;
		int unsigned                 tick;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_cp  = m_tdata[30:0];
				got_len = m_tdata[33:31];
				got_st  = m_tuser;
				if (cp_due.size() == 0) begin
					fault_cnt++;
					if (fault_cnt <= 10)
						$display("unexpected transfer: cp=%h st=%0d len=%0d",
							got_cp, got_st, got_len);
				end else begin
					want = cp_due.pop_front();
					if (got_cp != want.code_point || got_st != want.status ||
							got_len != want.seq_length) begin
						fault_cnt++;
						if (fault_cnt <= 10)
							$display("mismatch: cp=%h st=%0d len=%0d, wanted cp=%h st=%0d len=%0d",
								got_cp, got_st, got_len,
								want.code_point, want.status, want.seq_length);
					end
				end
			end
			if (tick % 64 == 0)
				pct = idle_pct();
			tick++;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (sent_cnt + QUIET_TAIL < total_bytes && $urandom_range(0, 99) < pct) begin
				stall_left = $urandom_range(1, 12) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : run
		logic [7:0]  opening [0:25];
		int          n;
		int unsigned r;
		int unsigned span;
		logic [31:0] ceiling;
		logic [31:0] top;
		logic [7:0]  bad;

		// nul, ascii top, stray continuations, 0xfe/0xff, two-byte extremes and
		// overlong, nul and ascii inside a sequence, lead above 0x10ffff, 31-bit max
		opening = '{8'h00, 8'h7f, 8'h80, 8'hbf, 8'hfe, 8'hff,
			8'hc2, 8'h80, 8'hc0, 8'h80, 8'hdf, 8'hbf, 8'he0, 8'h00, 8'hc3, 8'h41,
			8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf};
		foreach (opening[i])
			byte_backlog.push_back(opening[i]);

		while (byte_backlog.size() < 26 + RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				// well-formed sequence, sometimes overlong
				n       = $urandom_range(1, 6);
				top     = (32'd1 << payload_bits(n)) - 1;
				ceiling = (n == 1) ? 32'd0 : (32'd1 << payload_bits(n - 1)) - 1;
				if (n == 1)
					encode_cp(n, $urandom_range(0, 127));
				else if ($urandom_range(0, 9) == 0)
					encode_cp(n, $urandom_range(0, ceiling));
				else
					encode_cp(n, $urandom_range(ceiling + 1, top));
			end else if (r < 85) begin
				// truncated sequence cut off by nul or a non-continuation byte
				n    = $urandom_range(2, 6);
				span = $urandom_range(0, n - 2);
				byte_backlog.push_back(lead_byte(n, 8'($urandom)));
				repeat (span)
					byte_backlog.push_back(8'h80 | 8'($urandom_range(0, 63)));
				bad = 8'($urandom);
				if ($urandom_range(0, 3) == 0)
					bad = 8'h00;
				else if (bad[7:6] == 2'b10)
					bad[6] = 1'b1;
				byte_backlog.push_back(bad);
			end else begin
				byte_backlog.push_back(8'($urandom));
			end
		end
		total_bytes = byte_backlog.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_backlog.size() != 0 || cp_due.size() != 0)
			@(posedge clk);
		// catch any stray transfer after the last expected one
		repeat (12) @(posedge clk);

		if (fault_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ utf8_stream_decoder.f @@
sv/utf8d_pkg.sv
sv/utf8d_step.sv
sv/utf8_stream_decoder.sv
tb/testbench.sv
